// ----- hdl/tbrl_pkg.sv -----
// Shared constants for the token bucket rate limiter.
// Holds field widths, register indexes and reset values; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tbrl_pkg;

    localparam int TIME_W  = 48;
    localparam int LEVEL_W = 26;
    localparam int CFG_W   = 16;
    localparam int PROD_W  = LEVEL_W + CFG_W;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 32;

    localparam logic [LEVEL_W-1:0] TOKEN_SCALE = LEVEL_W'(1000);

    localparam logic [CFG_W-1:0] BURST_RESET = CFG_W'(16);
    localparam logic [CFG_W-1:0] RATE_RESET  = CFG_W'(8);
    localparam logic [LEVEL_W-1:0] CAP_RESET = LEVEL_W'(BURST_RESET) * TOKEN_SCALE;

    typedef enum logic [0:0] {
        REG_BURST_TOKENS = 1'b0,
        REG_REFILL_RATE  = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

// ----- hdl/token_bucket_rate_limiter.sv -----
// Top level of the token bucket rate limiter: input register, refill and spend
// logic, result register and configuration registers. Depends on tbrl_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One request is accepted per clock cycle unless m_tready stalls the result register;
// the accepted request is held in the input register until it advances, then the
// refill, clamp and spend logic writes the result register and the bucket state
// together. The rate is set by the loop through the level and last-refill-time
// registers, which holds one 48-bit subtract, one 26 x 16 multiplier and a few compares.
// After reset the bucket is marked unused, so the first request finds it full.
// The ceiling is kept as a scaled cap computed when burst_tokens is written;
// configuration must be written only while no request is in flight.
module token_bucket_rate_limiter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [tbrl_pkg::S_DATA_W-1:0]    s_tdata,   // now_ms
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [tbrl_pkg::M_DATA_W-1:0]         m_tdata,   // granted, level_after, zero pad
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_wr_index,
    input  wire logic [tbrl_pkg::CFG_W-1:0]       cfg_wr_data
);

    localparam int TW = tbrl_pkg::TIME_W;
    localparam int LW = tbrl_pkg::LEVEL_W;
    localparam int CW = tbrl_pkg::CFG_W;
    localparam int PW = tbrl_pkg::PROD_W;

    logic [LW-1:0] cap_reg;
    logic [CW-1:0] rate_reg;
    logic [LW-1:0] level_reg;
    logic [LW-1:0] level_next;
    logic [TW-1:0] last_time_reg;
    logic [TW-1:0] last_time_next;
    logic          in_valid_reg;
    logic [TW-1:0] now_reg;
    logic          out_valid_reg;
    logic          granted_reg;
    logic          granted_next;
    logic [LW-1:0] level_out_reg;
    logic          advance;

    logic [LW-1:0] lvl_start;
    logic [TW-1:0] last_start;
    logic          time_moved;
    logic [TW-1:0] elapsed;
    logic [PW-1:0] prod;
    logic [LW-1:0] missing;
    logic          saturate;
    logic [LW-1:0] lvl_fill;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tbrl_pkg::M_DATA_W - LW - 1){1'b0}}, level_out_reg, granted_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= tbrl_pkg::CAP_RESET;
            rate_reg <= tbrl_pkg::RATE_RESET;
        end else if (cfg_wr_en) begin
            unique case (tbrl_pkg::cfg_index_t'(cfg_wr_index))
                tbrl_pkg::REG_BURST_TOKENS: begin
                    cap_reg <= LW'({{(LW - CW){1'b0}}, cfg_wr_data} * tbrl_pkg::TOKEN_SCALE);
                end
                tbrl_pkg::REG_REFILL_RATE: begin
                    rate_reg <= cfg_wr_data;
                end
                default: begin
                    rate_reg <= rate_reg;
                end
            endcase
        end
    end

    always_comb begin
        if (last_time_reg == '0) begin
            lvl_start  = cap_reg;
            last_start = now_reg;
        end else begin
            lvl_start  = level_reg;
            last_start = last_time_reg;
        end
        time_moved = now_reg > last_start;
        elapsed    = now_reg - last_start;
        prod       = {{(PW - LW){1'b0}}, elapsed[LW-1:0]} * {{(PW - CW){1'b0}}, rate_reg};
        missing    = cap_reg - lvl_start;
        saturate   = ((elapsed[TW-1:LW] != '0) && (rate_reg != '0))
                     || (prod >= {{(PW - LW){1'b0}}, missing});

        if (lvl_start >= cap_reg) begin
            lvl_fill = cap_reg;
        end else if (time_moved && saturate) begin
            lvl_fill = cap_reg;
        end else if (time_moved) begin
            lvl_fill = lvl_start + prod[LW-1:0];
        end else begin
            lvl_fill = lvl_start;
        end

        last_time_next = time_moved ? now_reg : last_start;
        granted_next   = lvl_fill >= tbrl_pkg::TOKEN_SCALE;
        level_next     = granted_next ? (lvl_fill - tbrl_pkg::TOKEN_SCALE) : lvl_fill;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            level_reg     <= '0;
            last_time_reg <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                level_reg     <= level_next;
                last_time_reg <= last_time_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            now_reg <= s_tdata[TW-1:0];
        end
        if (advance) begin
            granted_reg   <= granted_next;
            level_out_reg <= level_next;
        end
    end

`ifndef ASSERT_OFF
    // A refused request leaves less than one whole token in the bucket.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !granted_reg) |-> (level_out_reg < tbrl_pkg::TOKEN_SCALE))
        else $error("refused request with a whole token left");

    // The reported level never exceeds the scaled ceiling.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (level_out_reg <= cap_reg))
        else $error("level above the bucket ceiling");

    // With the result register empty the input side is always open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with an empty result register");

    // A processed transaction always produces a pending result on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result lost after processing");
`endif

endmodule

`default_nettype wire

// ----- sim/token_bucket_checker.sv -----
// Checker for the token bucket rate limiter: watches the request, result and
// configuration ports, predicts every grant decision and compares it field by field.
// Depends on tbrl_pkg for widths, register indexes and reset values.
`timescale 1ns / 1ps

module token_bucket_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    input  wire logic                             s_tready,
    input  wire logic [tbrl_pkg::S_DATA_W-1:0]    s_tdata,   // now_ms
    input  wire logic                             m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [tbrl_pkg::M_DATA_W-1:0]    m_tdata,   // granted, level_after, zero pad
    input  wire logic                             cfg_wr_en,
    input  wire logic                             cfg_wr_index,
    input  wire logic [tbrl_pkg::CFG_W-1:0]       cfg_wr_data,
    output int unsigned                           mismatches,
    output int unsigned                           outstanding
);

    import tbrl_pkg::*;

    typedef struct packed {
        logic               granted;
        logic [LEVEL_W-1:0] level_after;
    } grant_result_t;

    grant_result_t      grant_queue[$];
    logic [CFG_W-1:0]   burst_tokens;
    logic [CFG_W-1:0]   refill_rate;
    logic [LEVEL_W-1:0] token_level;
    logic [TIME_W-1:0]  last_refill_ms;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("t=%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [LEVEL_W-1:0] refill_level(input logic [LEVEL_W-1:0] level,
                                                        input logic [TIME_W-1:0] elapsed,
                                                        input logic [LEVEL_W-1:0] cap);
        logic [63:0] gain;
        if (cap == '0) return '0;
        if (level >= cap) return cap;
        if (refill_rate == '0 || elapsed == '0) return level;
        gain = 64'(elapsed) * 64'(refill_rate);
        if (gain >= 64'(cap - level)) return cap;
        return level + gain[LEVEL_W-1:0];
    endfunction

    function automatic grant_result_t spend_token(input logic [TIME_W-1:0] now_ms);
        logic [LEVEL_W-1:0] cap;
        grant_result_t      res;
        cap = LEVEL_W'(burst_tokens) * TOKEN_SCALE;
        res.granted = 1'b0;
        // An unused bucket is marked by a stored time of zero and starts full.
        if (last_refill_ms == '0) begin
            token_level    = cap;
            last_refill_ms = now_ms;
        end
        if (now_ms > last_refill_ms) begin
            token_level    = refill_level(token_level, now_ms - last_refill_ms, cap);
            last_refill_ms = now_ms;
        end
        if (token_level > cap) token_level = cap;
        if (token_level >= TOKEN_SCALE) begin
            token_level = token_level - TOKEN_SCALE;
            res.granted = 1'b1;
        end
        res.level_after = token_level;
        return res;
    endfunction

    always @(posedge aclk) begin
        grant_result_t seen;
        grant_result_t want;
        if (!aresetn) begin
            grant_queue.delete();
            burst_tokens   = BURST_RESET;
            refill_rate    = RATE_RESET;
            token_level    = '0;
            last_refill_ms = '0;
            mismatches     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen.granted     = m_tdata[0];
                seen.level_after = m_tdata[LEVEL_W:1];
                if (grant_queue.size() == 0) begin
                    report_mismatch("unexpected result transaction",
                                    64'(seen.level_after), 64'(0));
                end else begin
                    want = grant_queue.pop_front();
                    if (seen.granted !== want.granted)
                        report_mismatch("granted", 64'(seen.granted), 64'(want.granted));
                    if (seen.level_after !== want.level_after)
                        report_mismatch("level_after", 64'(seen.level_after),
                                        64'(want.level_after));
                end
            end
            if (cfg_wr_en) begin
                if (cfg_wr_index == REG_BURST_TOKENS) burst_tokens = cfg_wr_data;
                else if (cfg_wr_index == REG_REFILL_RATE) refill_rate = cfg_wr_data;
            end
            if (s_tvalid && s_tready)
                grant_queue.push_back(spend_token(s_tdata[TIME_W-1:0]));
        end
        outstanding = grant_queue.size();
    end

endmodule

// ----- sim/tb_token_bucket_rate_limiter.sv -----
// Testbench top for the token bucket rate limiter: clock, reset, request and
// configuration stimulus, result-side back-pressure and the final verdict.
// Depends on tbrl_pkg, token_bucket_rate_limiter and token_bucket_checker.
`timescale 1ns / 1ps

module tb_token_bucket_rate_limiter;

    import tbrl_pkg::*;

    localparam int RUN_LIMIT      = 1000000;
    localparam int PHASE_COUNT    = 11;
    localparam int PHASE_REQUESTS = 100;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata      = '0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en    = 1'b0;
    logic                  cfg_wr_index = REG_BURST_TOKENS;
    logic [CFG_W-1:0]      cfg_wr_data  = '0;

    int unsigned           mismatches;
    int unsigned           outstanding;
    int unsigned           cycle_count;
    int unsigned           ready_hold   = 0;
    int unsigned           ready_pick;
    bit                    sender_gaps;
    logic [TIME_W-1:0]     now_cursor;

    always #5 aclk = ~aclk;

    token_bucket_rate_limiter dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    token_bucket_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 5) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(100, 300);
            end else if (ready_pick < 50) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 40);
            end else if (ready_pick < 90) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 60);
            end
        end
    end

    task automatic send_request(input logic [TIME_W-1:0] now_ms);
        s_tdata  <= S_DATA_W'(now_ms);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic sender_pause();
        int unsigned pick;
        int unsigned gap;
        if (!sender_gaps) return;
        pick = $urandom_range(0, 99);
        if (pick < 70) gap = 0;
        else if (pick < 93) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 50);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_bucket(input logic [CFG_W-1:0] burst, input logic [CFG_W-1:0] rate);
        drain_results();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_BURST_TOKENS;
        cfg_wr_data  <= burst;
        @(posedge aclk);
        cfg_wr_index <= REG_REFILL_RATE;
        cfg_wr_data  <= rate;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] next_request_time();
        int unsigned       pick;
        logic [TIME_W-1:0] wide;
        pick = $urandom_range(0, 99);
        wide = TIME_W'({$urandom, $urandom});
        if (pick < 40) begin
            now_cursor += TIME_W'($urandom_range(0, 3));
        end else if (pick < 65) begin
            now_cursor += TIME_W'($urandom_range(0, 400));
        end else if (pick < 75) begin
            now_cursor += TIME_W'($urandom_range(0, 20000));
        end else if (pick < 85) begin
            // Same time again: no refill.
        end else if (pick < 95) begin
            return wide % (now_cursor + 1);
        end else if (pick < 97) begin
            return '0;
        end else if (now_cursor < 48'h4000_0000_0000) begin
            now_cursor += wide & 48'h0FFF_FFFF_FFFF;
        end else begin
            now_cursor += 1;
        end
        return now_cursor;
    endfunction

    initial begin
        for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [CFG_W-1:0] burst;
        logic [CFG_W-1:0] rate;
        sender_gaps = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: unused bucket at time zero, standstill, time
        // going backwards and an exact one-token refill.
        send_request(0);
        send_request(0);
        send_request(10);
        send_request(10);
        send_request(4);
        send_request(135);

        // Lowering the ceiling clamps the level without any time passing.
        set_bucket(1, 8);
        send_request(135);
        send_request(135);
        send_request(260);

        set_bucket(0, 8);
        send_request(500);

        set_bucket(16'hFFFF, 16'hFFFF);
        send_request(501);
        send_request(2000);
        send_request(2000);

        now_cursor = 2000;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin burst = 2;       rate = 8;       end
                1: begin burst = 0;       rate = 100;     end
                2: begin burst = 16'hFFFF; rate = 16'hFFFF; end
                3: begin burst = 3;       rate = 0;       end
                4: begin burst = 1;       rate = 1;       end
                5: begin burst = 4;       rate = 1000;    end
                6: begin burst = 16'hFFFF; rate = 0;       end
                7: begin burst = 0;       rate = 0;       end
                8: begin
                    burst = CFG_W'($urandom_range(1, 20));
                    rate  = CFG_W'($urandom_range(1, 2000));
                end
                9: begin
                    burst = CFG_W'($urandom_range(0, 16'hFFFF));
                    rate  = CFG_W'($urandom_range(0, 16'hFFFF));
                end
                default: begin burst = BURST_RESET; rate = RATE_RESET; end
            endcase
            set_bucket(burst, rate);
            sender_gaps = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < PHASE_REQUESTS; i++) begin
                sender_pause();
                send_request(next_request_time());
            end
        end

        send_request('1);
        repeat (4) send_request(TIME_W'({$urandom, $urandom}));

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
